// ===== design/pnht_pkg.sv =====
// package for the polyline nearest hit test
// word types, sequencer enums and fixed widths; no dependencies

package pnht_pkg;

  localparam int COORD_W    = 16;
  localparam int IDX_OUT_W  = 10;
  localparam int SEG_DIST_W = 41;
  localparam int VTX_DIST_W = 33;
  localparam int TOL_W      = 16;
  localparam int DIV_STEPS  = 42;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd768;

  localparam logic FUNC_START  = 1'b0;
  localparam logic FUNC_VERTEX = 1'b1;

  typedef struct packed {
    logic                      func;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
  } pnht_in_t;

  typedef struct packed {
    logic                  seg_valid;
    logic [IDX_OUT_W-1:0]  nearest_segment;
    logic [SEG_DIST_W-1:0] seg_dist_sq;
    logic                  segment_hit;
    logic                  line_near;
    logic                  vertex_valid;
    logic [IDX_OUT_W-1:0]  nearest_vertex;
    logic [VTX_DIST_W-1:0] vertex_dist_sq;
    logic                  vertex_hit;
    logic                  overflow;
  } pnht_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_UPD,
    ST_TOL,
    ST_EMIT
  } pnht_state_e;

  typedef enum logic [3:0] {
    STEP_DX2,
    STEP_DY2,
    STEP_EX2,
    STEP_EY2,
    STEP_DOT_X,
    STEP_DOT_Y,
    STEP_CRS_A,
    STEP_CRS_B,
    STEP_CRS_END,
    STEP_A00,
    STEP_A01,
    STEP_A11,
    STEP_NUM_END
  } pnht_step_e;

endpackage

// ===== design/polyline_nearest_hit_test.sv =====
// polyline nearest hit test: point-to-vertex and point-to-segment minima
// one shared 18x18 multiplier and a radix-2 restoring divider; uses pnht_pkg
// a start item needs no arithmetic; a vertex item runs the 42-step division
// unless it opens no segment or is clamped; a last item goes via ST_TOL to ST_EMIT
// throughput: one item at a time, set by the multiplier steps and the divider
// result sits in an output register so the next item can be taken meanwhile
// reset: asynchronous; polyline state cleared, tolerance to 3.0, no sweep

module polyline_nearest_hit_test #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  pnht_pkg::pnht_in_t        in_word_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output pnht_pkg::pnht_out_t       out_word_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [pnht_pkg::TOL_W-1:0] cfg_word_i
);

  import pnht_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int IDX_W = $clog2(MAX_POINTS);

  pnht_state_e state_q, state_d;
  pnht_step_e  step_q, step_d;

  logic [TOL_W-1:0]          tolerance_q;
  logic signed [COORD_W-1:0] query_x_q, query_y_q, prev_x_q, prev_y_q;
  logic signed [COORD_W-1:0] item_x_q, item_y_q;
  logic                      item_last_q;
  logic [CNT_W-1:0]          count_q;
  logic [41:0]               best_sd_q;
  logic [IDX_W-1:0]          best_sidx_q;
  logic [33:0]               best_vd_q;
  logic [IDX_W-1:0]          best_vidx_q;
  logic                      ovf_q;
  logic [33:0]               prev_vd_q;

  logic signed [35:0] prod_q, vd_q, l2_q, dot_q, cross_q;
  logic [66:0]        num_q;
  logic [33:0]        rem_q;
  logic [41:0]        nlo_q;
  logic [5:0]         div_cnt_q;
  logic [41:0]        sd_q;
  logic               seg_en_q;

  logic              out_valid_q;
  pnht_out_t         out_q;

  logic              accept, full, out_free, mul_en, seg_short, div_done;
  logic signed [16:0] dx, dy, ex, ey, pxd, pyd;
  logic signed [35:0] abs_cross;
  logic [33:0]        a_mag;
  logic signed [17:0] op_a, op_b;
  logic [66:0]        num_full;
  logic [33:0]        trial, divisor;
  logic               qbit;
  logic [CNT_W-1:0]   cnt_m1;
  logic               sv, vv;
  logic [31:0]        tol2, sidx_ext, vidx_ext;
  logic [48:0]        seg_scaled, vtx_scaled;
  pnht_out_t          out_d;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign full        = (count_q >= CNT_W'(MAX_POINTS));

  // coordinate differences
  assign dx  = {query_x_q[COORD_W-1], query_x_q} - {item_x_q[COORD_W-1], item_x_q};
  assign dy  = {query_y_q[COORD_W-1], query_y_q} - {item_y_q[COORD_W-1], item_y_q};
  assign ex  = {item_x_q[COORD_W-1], item_x_q} - {prev_x_q[COORD_W-1], prev_x_q};
  assign ey  = {item_y_q[COORD_W-1], item_y_q} - {prev_y_q[COORD_W-1], prev_y_q};
  assign pxd = {query_x_q[COORD_W-1], query_x_q} - {prev_x_q[COORD_W-1], prev_x_q};
  assign pyd = {query_y_q[COORD_W-1], query_y_q} - {prev_y_q[COORD_W-1], prev_y_q};

  assign abs_cross = cross_q[35] ? -cross_q : cross_q;
  assign a_mag     = abs_cross[33:0];

  assign seg_short = (count_q == '0) || (l2_q == '0) || dot_q[35] || (dot_q > l2_q);
  assign num_full  = num_q + (67'(prod_q[34:0]) << 34);

  // restoring divide step
  assign divisor  = l2_q[33:0];
  assign trial    = {rem_q[32:0], nlo_q[41]};
  assign qbit     = (trial >= divisor);
  assign div_done = (div_cnt_q == 6'(DIV_STEPS - 1));

  assign cnt_m1 = count_q - CNT_W'(1);

  // shared multiplier operand select
  always_comb begin
    mul_en = 1'b0;
    op_a   = '0;
    op_b   = '0;
    if (state_q == ST_TOL) begin
      mul_en = 1'b1;
      op_a   = {2'b00, tolerance_q};
      op_b   = {2'b00, tolerance_q};
    end else if (state_q == ST_CALC) begin
      mul_en = 1'b1;
      unique case (step_q)
        STEP_DX2: begin
          op_a = {dx[16], dx};
          op_b = {dx[16], dx};
        end
        STEP_DY2: begin
          op_a = {dy[16], dy};
          op_b = {dy[16], dy};
        end
        STEP_EX2: begin
          op_a = {ex[16], ex};
          op_b = {ex[16], ex};
        end
        STEP_EY2: begin
          op_a = {ey[16], ey};
          op_b = {ey[16], ey};
        end
        STEP_DOT_X: begin
          op_a = {pxd[16], pxd};
          op_b = {ex[16], ex};
        end
        STEP_DOT_Y: begin
          op_a = {pyd[16], pyd};
          op_b = {ey[16], ey};
        end
        STEP_CRS_A: begin
          op_a = {pxd[16], pxd};
          op_b = {ey[16], ey};
        end
        STEP_CRS_B: begin
          op_a = {pyd[16], pyd};
          op_b = {ex[16], ex};
        end
        STEP_A00: begin
          op_a = {1'b0, a_mag[16:0]};
          op_b = {1'b0, a_mag[16:0]};
        end
        STEP_A01: begin
          op_a = {1'b0, a_mag[16:0]};
          op_b = {1'b0, a_mag[33:17]};
        end
        STEP_A11: begin
          op_a = {1'b0, a_mag[33:17]};
          op_b = {1'b0, a_mag[33:17]};
        end
        default: begin
          mul_en = 1'b0;
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_word_i.func == FUNC_VERTEX && !full) begin
            state_d = ST_CALC;
            step_d  = STEP_DX2;
          end else if (in_word_i.last) begin
            state_d = ST_TOL;
          end
        end
      end
      ST_CALC: begin
        if (step_q == STEP_A00 && seg_short) begin
          state_d = ST_UPD;
        end else if (step_q == STEP_NUM_END) begin
          state_d = ST_DIV;
        end else begin
          step_d = pnht_step_e'(step_q + 4'd1);
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        state_d = item_last_q ? ST_TOL : ST_IDLE;
      end
      ST_TOL: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STEP_DX2;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // result word
  assign sv         = (count_q >= CNT_W'(2));
  assign vv         = (count_q != '0);
  assign tol2       = prod_q[31:0];
  assign seg_scaled = {best_sd_q[SEG_DIST_W-1:0], 8'b0};
  assign vtx_scaled = {best_vd_q[VTX_DIST_W-1:0], 16'b0};
  assign sidx_ext   = 32'(best_sidx_q);
  assign vidx_ext   = 32'(best_vidx_q);

  always_comb begin
    out_d.seg_valid       = sv;
    out_d.nearest_segment = sv ? sidx_ext[IDX_OUT_W-1:0] : '0;
    out_d.seg_dist_sq     = sv ? best_sd_q[SEG_DIST_W-1:0] : '0;
    out_d.segment_hit     = sv && (seg_scaled <= 49'(tol2));
    out_d.line_near       = sv && (seg_scaled < 49'(tol2));
    out_d.vertex_valid    = vv;
    out_d.nearest_vertex  = vv ? vidx_ext[IDX_OUT_W-1:0] : '0;
    out_d.vertex_dist_sq  = vv ? best_vd_q[VTX_DIST_W-1:0] : '0;
    out_d.vertex_hit      = vv && (vtx_scaled <= 49'(tol2));
    out_d.overflow        = ovf_q;
  end

  // config, output register and polyline state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tolerance_q <= TOL_RESET;
      query_x_q   <= '0;
      query_y_q   <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_vd_q   <= '0;
      count_q     <= '0;
      best_sd_q   <= '0;
      best_sidx_q <= '0;
      best_vd_q   <= '0;
      best_vidx_q <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        tolerance_q <= cfg_word_i;
      end
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (in_word_i.func == FUNC_START) begin
              query_x_q   <= in_word_i.x;
              query_y_q   <= in_word_i.y;
              count_q     <= '0;
              best_sd_q   <= '0;
              best_sidx_q <= '0;
              best_vd_q   <= '0;
              best_vidx_q <= '0;
              ovf_q       <= 1'b0;
            end else if (full) begin
              ovf_q <= 1'b1;
            end
          end
        end
        ST_UPD: begin
          if (count_q == '0 || vd_q[33:0] < best_vd_q) begin
            best_vd_q   <= vd_q[33:0];
            best_vidx_q <= count_q[IDX_W-1:0];
          end
          if (seg_en_q && (count_q == CNT_W'(1) || sd_q < best_sd_q)) begin
            best_sd_q   <= sd_q;
            best_sidx_q <= cnt_m1[IDX_W-1:0];
          end
          prev_x_q  <= item_x_q;
          prev_y_q  <= item_y_q;
          prev_vd_q <= vd_q[33:0];
          count_q   <= count_q + CNT_W'(1);
        end
        ST_EMIT: begin
          if (out_free) begin
            out_q       <= out_d;
            count_q     <= '0;
            best_sd_q   <= '0;
            best_sidx_q <= '0;
            best_vd_q   <= '0;
            best_vidx_q <= '0;
            ovf_q       <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // arithmetic datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_x_q    <= in_word_i.x;
      item_y_q    <= in_word_i.y;
      item_last_q <= in_word_i.last;
    end
    if (mul_en) begin
      prod_q <= op_a * op_b;
    end
    if (state_q == ST_CALC) begin
      unique case (step_q)
        STEP_DY2:     vd_q    <= prod_q;
        STEP_EX2:     vd_q    <= vd_q + prod_q;
        STEP_EY2:     l2_q    <= prod_q;
        STEP_DOT_X:   l2_q    <= l2_q + prod_q;
        STEP_DOT_Y:   dot_q   <= prod_q;
        STEP_CRS_A:   dot_q   <= dot_q + prod_q;
        STEP_CRS_B:   cross_q <= prod_q;
        STEP_CRS_END: cross_q <= cross_q - prod_q;
        STEP_A00: begin
          seg_en_q <= (count_q != '0);
          if (l2_q == '0 || dot_q[35]) begin
            sd_q <= {prev_vd_q, 8'b0};
          end else begin
            sd_q <= {vd_q[33:0], 8'b0};
          end
        end
        STEP_A01:     num_q   <= 67'(prod_q[34:0]);
        STEP_A11:     num_q   <= num_q + (67'(prod_q[34:0]) << 18);
        STEP_NUM_END: begin
          rem_q     <= {1'b0, num_full[66:34]};
          nlo_q     <= {num_full[33:0], 8'b0};
          div_cnt_q <= '0;
        end
        default: begin
        end
      endcase
    end
    if (state_q == ST_DIV) begin
      rem_q     <= qbit ? (trial - divisor) : trial;
      nlo_q     <= {nlo_q[40:0], qbit};
      div_cnt_q <= div_cnt_q + 6'd1;
      if (div_done) begin
        sd_q <= {nlo_q[40:0], qbit};
      end
    end
  end

endmodule

// ===== tb/polyline_nearest_hit_test_tb.sv =====
// testbench for polyline_nearest_hit_test: directed and random polylines checked
// word by word against an in-line predictor of the nearest vertex and segment
// depends on pnht_pkg and polyline_nearest_hit_test
`timescale 1ns / 1ps

module polyline_nearest_hit_test_tb;
  import pnht_pkg::*;

  localparam int          CAPACITY   = 1024;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int          SETTLE     = 80;
  localparam int          LONG_HOLD  = 400;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  pnht_in_t           in_word_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  pnht_out_t          out_word_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [TOL_W-1:0]   cfg_word_i  = '0;

  pnht_in_t  pending_words_q[$];
  pnht_out_t expected_hits_q[$];
  pnht_out_t want_w;

  logic        word_taken   = 1'b0;
  int          send_gap_pct = 0;
  int          stall_pct    = 0;
  logic        want_hold    = 1'b0;
  logic        hold_done    = 1'b0;
  int          hold_left    = 0;
  int          err_cnt      = 0;
  int unsigned cycle_cnt    = 0;

  // predictor state
  logic [TOL_W-1:0] tol_q88 = TOL_RESET;
  longint           qry_x = 0, qry_y = 0, prv_x = 0, prv_y = 0;
  int               n_vtx = 0, best_seg_idx = 0, best_vtx_idx = 0;
  longint unsigned  best_seg = 0, best_vtx = 0;
  logic             ovf_seen = 1'b0;

  // query point the generator is aiming at
  logic [15:0] gen_qx = '0, gen_qy = '0;

  polyline_nearest_hit_test #(
    .MAX_POINTS(CAPACITY)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_word_i (cfg_word_i)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic longint unsigned point_dist_sq(longint ax, longint ay,
                                                    longint bx, longint by);
    longint dx, dy;
    dx = ax - bx;
    dy = ay - by;
    return dx * dx + dy * dy;
  endfunction

  function automatic longint unsigned segment_dist_sq_q8(longint vx, longint vy,
                                                         longint wx, longint wy);
    longint       ex, ey, px, py, l2, dot, crs;
    logic [127:0] mag, num;
    ex = wx - vx;
    ey = wy - vy;
    px = qry_x - vx;
    py = qry_y - vy;
    l2 = ex * ex + ey * ey;
    dot = px * ex + py * ey;
    if (l2 == 0 || dot < 0) return point_dist_sq(qry_x, qry_y, vx, vy) << 8;
    if (dot > l2) return point_dist_sq(qry_x, qry_y, wx, wy) << 8;
    crs = px * ey - py * ex;
    if (crs < 0) crs = -crs;
    mag = 128'(crs);
    num = (mag * mag) << 8;
    num = num / 128'(l2);
    return num[63:0];
  endfunction

  function automatic void clear_polyline();
    n_vtx = 0;
    best_seg = 0;
    best_seg_idx = 0;
    best_vtx = 0;
    best_vtx_idx = 0;
    ovf_seen = 1'b0;
  endfunction

  function automatic void take_word(pnht_in_t w);
    longint          x, y;
    longint unsigned vd, sd, tol2;
    bit              sv, vv;
    pnht_out_t       r;
    x = longint'(w.x);
    y = longint'(w.y);
    if (w.func == FUNC_START) begin
      qry_x = x;
      qry_y = y;
      clear_polyline();
    end else if (n_vtx >= CAPACITY) begin
      ovf_seen = 1'b1;
    end else begin
      vd = point_dist_sq(qry_x, qry_y, x, y);
      if (n_vtx == 0 || vd < best_vtx) begin
        best_vtx = vd;
        best_vtx_idx = n_vtx;
      end
      if (n_vtx >= 1) begin
        sd = segment_dist_sq_q8(prv_x, prv_y, x, y);
        if (n_vtx == 1 || sd < best_seg) begin
          best_seg = sd;
          best_seg_idx = n_vtx - 1;
        end
      end
      prv_x = x;
      prv_y = y;
      n_vtx++;
    end
    if (w.last) begin
      tol2 = 64'(tol_q88) * 64'(tol_q88);
      sv = n_vtx >= 2;
      vv = n_vtx >= 1;
      sd = sv ? 64'(best_seg[SEG_DIST_W-1:0]) : 64'd0;
      vd = vv ? 64'(best_vtx[VTX_DIST_W-1:0]) : 64'd0;
      r = '0;
      r.seg_valid       = sv;
      r.nearest_segment = sv ? best_seg_idx[IDX_OUT_W-1:0] : '0;
      r.seg_dist_sq     = sd[SEG_DIST_W-1:0];
      r.segment_hit     = sv && ((sd << 8) <= tol2);
      r.line_near       = sv && ((sd << 8) < tol2);
      r.vertex_valid    = vv;
      r.nearest_vertex  = vv ? best_vtx_idx[IDX_OUT_W-1:0] : '0;
      r.vertex_dist_sq  = vd[VTX_DIST_W-1:0];
      r.vertex_hit      = vv && ((vd << 16) <= tol2);
      r.overflow        = ovf_seen;
      expected_hits_q.push_back(r);
      clear_polyline();
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // acceptance and prediction
  always @(posedge clk_i) begin
    word_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) take_word(in_word_i);
  end

  // result checking
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_hits_q.size() == 0) begin
        report_mismatch("result word with none pending");
      end else begin
        want_w = expected_hits_q.pop_front();
        check_field("seg_valid", 64'(out_word_o.seg_valid), 64'(want_w.seg_valid));
        check_field("nearest_segment", 64'(out_word_o.nearest_segment),
                    64'(want_w.nearest_segment));
        check_field("seg_dist_sq", 64'(out_word_o.seg_dist_sq),
                    64'(want_w.seg_dist_sq));
        check_field("segment_hit", 64'(out_word_o.segment_hit),
                    64'(want_w.segment_hit));
        check_field("line_near", 64'(out_word_o.line_near), 64'(want_w.line_near));
        check_field("vertex_valid", 64'(out_word_o.vertex_valid),
                    64'(want_w.vertex_valid));
        check_field("nearest_vertex", 64'(out_word_o.nearest_vertex),
                    64'(want_w.nearest_vertex));
        check_field("vertex_dist_sq", 64'(out_word_o.vertex_dist_sq),
                    64'(want_w.vertex_dist_sq));
        check_field("vertex_hit", 64'(out_word_o.vertex_hit), 64'(want_w.vertex_hit));
        check_field("overflow", 64'(out_word_o.overflow), 64'(want_w.overflow));
      end
    end
  end

  // input word driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || word_taken)) begin
      if (pending_words_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        in_word_i  <= pending_words_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result stall, with one long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (want_hold && !hold_done) begin
      hold_done   <= 1'b1;
      hold_left   <= LONG_HOLD;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("polyline_nearest_hit_test_tb: errors");
      $finish;
    end
  end

  function automatic void push_word(logic f, logic [15:0] x, logic [15:0] y,
                                    logic l);
    pnht_in_t w;
    w.func = f;
    w.x    = x;
    w.y    = y;
    w.last = l;
    pending_words_q.push_back(w);
  endfunction

  function automatic logic [15:0] near_coord(logic [15:0] base);
    int r, d;
    r = $urandom_range(99);
    if (r < 10) return 16'($urandom_range(65535));
    if (r < 16) return r[0] ? 16'h8000 : 16'h7fff;
    if (r < 40) d = $urandom_range(8) - 4;
    else d = $urandom_range(600) - 300;
    return base + d[15:0];
  endfunction

  function automatic void pick_query();
    int r;
    r = $urandom_range(99);
    if (r < 60) begin
      gen_qx = 16'($urandom_range(2000) - 1000);
      gen_qy = 16'($urandom_range(2000) - 1000);
    end else if (r < 90) begin
      gen_qx = 16'($urandom_range(65535));
      gen_qy = 16'($urandom_range(65535));
    end else begin
      gen_qx = $urandom_range(1) ? 16'h8000 : 16'h7fff;
      gen_qy = $urandom_range(1) ? 16'h8000 : 16'h7fff;
    end
  endfunction

  function automatic void queue_directed();
    // lone vertex straight after reset, query still at the origin
    push_word(FUNC_VERTEX, 16'd3, 16'd0, 1'b1);
    // start marked last
    push_word(FUNC_START, 16'd0, 16'd0, 1'b1);
    // segment exactly on the tolerance
    push_word(FUNC_START, 16'd0, 16'd0, 1'b0);
    push_word(FUNC_VERTEX, -16'sd5, 16'd3, 1'b0);
    push_word(FUNC_VERTEX, 16'd5, 16'd3, 1'b1);
    // zero-length segment and a tied vertex
    push_word(FUNC_START, 16'd10, 16'd10, 1'b0);
    push_word(FUNC_VERTEX, 16'd13, 16'd14, 1'b0);
    push_word(FUNC_VERTEX, 16'd13, 16'd14, 1'b1);
    // clamped at the start end and two true projections
    push_word(FUNC_START, 16'd0, 16'd0, 1'b0);
    push_word(FUNC_VERTEX, 16'd5, 16'd0, 1'b0);
    push_word(FUNC_VERTEX, 16'd10, 16'd0, 1'b0);
    push_word(FUNC_VERTEX, 16'd10, 16'd5, 1'b0);
    push_word(FUNC_VERTEX, -16'sd2, 16'd1, 1'b1);
    // coordinate extremes
    push_word(FUNC_START, 16'h8000, 16'h8000, 1'b0);
    push_word(FUNC_VERTEX, 16'h7fff, 16'h7fff, 1'b0);
    push_word(FUNC_VERTEX, 16'h7fff, 16'h8000, 1'b0);
    push_word(FUNC_VERTEX, 16'h8000, 16'h7fff, 1'b1);
    // new polyline on the held query
    push_word(FUNC_VERTEX, 16'd1, 16'd1, 1'b1);
    push_word(FUNC_START, 16'h7fff, 16'h7fff, 1'b0);
    push_word(FUNC_VERTEX, 16'h8000, 16'h8000, 1'b0);
    push_word(FUNC_VERTEX, 16'h7fff, 16'h8000, 1'b1);
  endfunction

  function automatic void queue_over_capacity();
    int          i, dx, dy;
    logic [15:0] vx, vy;
    gen_qx = 16'($urandom_range(1000) - 500);
    gen_qy = 16'($urandom_range(1000) - 500);
    push_word(FUNC_START, gen_qx, gen_qy, 1'b0);
    // all kept vertices far to one side except the last kept one on the query
    for (i = 0; i < CAPACITY + 3; i++) begin
      if (i == CAPACITY - 1) begin
        vx = gen_qx;
        vy = gen_qy;
      end else if (i >= CAPACITY) begin
        vx = 16'($urandom_range(65535));
        vy = 16'($urandom_range(65535));
      end else begin
        dx = 100 + $urandom_range(500);
        dy = $urandom_range(1000) - 500;
        vx = gen_qx + dx[15:0];
        vy = gen_qy + dy[15:0];
      end
      push_word(FUNC_VERTEX, vx, vy, i == CAPACITY + 2);
    end
  endfunction

  function automatic void queue_random(int n);
    int   base, kind, nv, i;
    logic l;
    base = pending_words_q.size();
    while (pending_words_q.size() - base < n) begin
      kind = $urandom_range(99);
      if (kind >= 8) begin
        pick_query();
        l = ($urandom_range(99) < 4);
        push_word(FUNC_START, gen_qx, gen_qy, l);
        if (l) continue;
      end
      nv = ($urandom_range(99) < 85) ? $urandom_range(8, 1) : $urandom_range(30);
      for (i = 0; i < nv; i++) begin
        if ($urandom_range(99) < 2) begin
          pick_query();
          push_word(FUNC_START, gen_qx, gen_qy, 1'b0);
        end
        l = (i == nv - 1) && ($urandom_range(99) >= 5);
        push_word(FUNC_VERTEX, near_coord(gen_qx), near_coord(gen_qy), l);
      end
    end
  endfunction

  task automatic write_tolerance(logic [TOL_W-1:0] val);
    @(negedge clk_i);
    cfg_word_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    tol_q88 = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_words_q.size() != 0 || in_valid_i || expected_hits_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_tolerance(TOL_RESET);
    @(posedge clk_i);
    queue_directed();
    drain();

    write_tolerance('0);
    @(posedge clk_i);
    queue_over_capacity();
    queue_random(100);
    drain();

    write_tolerance('1);
    @(posedge clk_i);
    send_gap_pct = 49;
    queue_random(130);
    drain();

    write_tolerance(TOL_W'($urandom_range(65535)));
    @(posedge clk_i);
    send_gap_pct = 0;
    stall_pct    = 49;
    want_hold    = 1'b1;
    queue_random(130);
    drain();

    write_tolerance(TOL_W'($urandom_range(4096, 256)));
    @(posedge clk_i);
    send_gap_pct = 29;
    stall_pct    = 29;
    queue_random(130);
    drain();

    if (err_cnt == 0) begin
      $display("polyline_nearest_hit_test_tb: clean");
    end else begin
      $display("polyline_nearest_hit_test_tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/pnht_pkg.sv
design/polyline_nearest_hit_test.sv
tb/polyline_nearest_hit_test_tb.sv
